// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the slice distance unit. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Full property, clocked and disabled while reset is active.
`define MSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication from an antecedent to a consequent sequence.
`define MSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slice distance package
// Widths, constants, the word passed along the cell row and the constant
// tables for the final scaling by a power of three.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Basic sizes.
  localparam int unsigned ORDER     = 8;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned DIST_W    = 34;
  localparam int unsigned LANES     = 4;

  // Derived widths.
  localparam int unsigned CW      = IN_W + 3;
  localparam int unsigned TW      = FRAC_BITS + 2;
  localparam int unsigned UW      = TW + 2;
  localparam int unsigned DMW     = FRAC_BITS;
  localparam int unsigned MAG_W   = FRAC_BITS + 1;
  localparam int unsigned PROD_W  = DMW + MAG_W;
  localparam int unsigned LVL_W   = $clog2(ORDER);
  localparam int unsigned SH_W    = $clog2(PROD_W);
  localparam int unsigned SAT_W   = (CW > DIST_W) ? CW : DIST_W;
  localparam int unsigned LATENCY = ORDER + 3;

  // Fixed-point constants.
  localparam logic [CW-1:0]        ONE_C      = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]        HALF_C     = ONE_C >> 1;
  localparam logic [FRAC_BITS:0]   ONE_R      = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [UW-1:0]        THREE_U    = UW'(3) << FRAC_BITS;
  localparam logic [UW-1:0]        SIX_U      = THREE_U << 1;
  localparam logic [SAT_W-1:0]     DIST_MAX_C = (SAT_W'(1) << DIST_W) - SAT_W'(1);

  // Word that travels down the cell row.
  typedef struct packed {
    logic                          resolved;
    logic                          hole;
    logic [LVL_W-1:0]              lvl;
    logic [DIST_W-1:0]             val;
    logic [LANES-1:0][TW-1:0]      t;
  } msd_word_t;

  typedef logic [ORDER-1:0][MAG_W-1:0] mag_tbl_t;
  typedef logic [ORDER-1:0][SH_W-1:0]  sh_tbl_t;

  // Reciprocal multipliers: ceil(2^s / 3^m) with s = FRAC_BITS + clog2(3^m).
  function automatic mag_tbl_t build_mag();
    mag_tbl_t          tbl;
    longint unsigned   p;
    longint unsigned   q;
    int                s;
    tbl = '0;
    for (int m = 1; m < ORDER; m++) begin
      p = 1;
      for (int k = 0; k < m; k++) begin
        p = p * 3;
      end
      s = FRAC_BITS + $clog2(p);
      q = 64'd1 << s;
      for (int k = 0; k < m; k++) begin
        q = q / 3;
      end
      tbl[m] = MAG_W'(q + 1);
    end
    return tbl;
  endfunction

  // Matching right shifts for each level.
  function automatic sh_tbl_t build_shift();
    sh_tbl_t           tbl;
    longint unsigned   p;
    tbl = '0;
    for (int m = 1; m < ORDER; m++) begin
      p = 1;
      for (int k = 0; k < m; k++) begin
        p = p * 3;
      end
      tbl[m] = SH_W'(FRAC_BITS + $clog2(p));
    end
    return tbl;
  endfunction

  localparam mag_tbl_t MAG_TBL   = build_mag();
  localparam sh_tbl_t  SHIFT_TBL = build_shift();

endpackage

// File: hdl/menger4d_slice_distance_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Menger 4D slice distance unit
// Approximate distance from a 3D point to a slice of a 4D Menger sponge.
// ----------------------------------------------------------------------------
// Usage:
//   A word (px_i, py_i, pz_i, signed Q4.28) is taken at each rising edge
//   where start_i is high and busy_o is low. busy_o is always low, so a new
//   word may be issued in every cycle.
//   Each word gives one result word on distance_o (unsigned Q6.28) and
//   inside_res_o, marked by done_o for exactly one cycle. Results leave in the
//   order the words came in, one per cycle at most.
//   The pipeline holds two front-end stages (offset and range test), one
//   cell per ternary level (ORDER - 1 cells), a multiply stage for the
//   3^-level scaling and the output register.
//   Reset clears all valid bits; words in flight are dropped and no result
//   appears until new words are issued.
//   The receiver cannot stall: a result is valid only in its strobe cycle.
// ----------------------------------------------------------------------------
module menger4d_slice_distance_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [msd_pkg::IN_W-1:0] px_i,
  input  logic signed [msd_pkg::IN_W-1:0] py_i,
  input  logic signed [msd_pkg::IN_W-1:0] pz_i,
  output logic                            done_o,
  output logic [msd_pkg::DIST_W-1:0]      distance_o,
  output logic                            inside_res_o
);

  logic                                cvalid [msd_pkg::ORDER];
  msd_pkg::msd_word_t                  cword  [msd_pkg::ORDER];

  // The pipeline never blocks.
  assign busy_o = 1'b0;

  // Offset, fourth coordinate and range test.
  msd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .px_i    (px_i),
    .py_i    (py_i),
    .pz_i    (pz_i),
    .valid_o (cvalid[0]),
    .word_o  (cword[0])
  );

  // One cell per ternary level.
  for (genvar g = 1; g < msd_pkg::ORDER; g++) begin : g_cell
    msd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cvalid[g-1]),
      .word_i  (cword[g-1]),
      .valid_o (cvalid[g]),
      .word_o  (cword[g])
    );
  end

  // Scaling and output register.
  msd_tail u_tail (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (cvalid[msd_pkg::ORDER-1]),
    .word_i       (cword[msd_pkg::ORDER-1]),
    .done_o       (done_o),
    .distance_o   (distance_o),
    .inside_res_o (inside_res_o)
  );

  // Fixed latency, and the inside flag agrees with a zero distance.
  `MSD_ASSERT_IMPL(a_top_latency, clk_i, rst_ni, start_i && !busy_o, ##(msd_pkg::LATENCY) done_o, "result strobe missing after fixed latency")
  `MSD_ASSERT(a_top_inside, clk_i, rst_ni, done_o |-> (inside_res_o == (distance_o == '0)), "inside flag disagrees with distance")

endmodule

// File: hdl/msd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slice distance front end
// Shifts the point into the unit cube, forms the fourth coordinate and
// resolves points that lie outside the cube by their smallest excess.
// ----------------------------------------------------------------------------
module msd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [msd_pkg::IN_W-1:0] px_i,
  input  logic signed [msd_pkg::IN_W-1:0] py_i,
  input  logic signed [msd_pkg::IN_W-1:0] pz_i,
  output logic                           valid_o,
  output msd_pkg::msd_word_t             word_o
);

  localparam int unsigned EXT = msd_pkg::CW - msd_pkg::IN_W;

  logic                                          valid_a_q;
  logic [msd_pkg::LANES-1:0][msd_pkg::CW-1:0]    c_d, c_q;
  logic [msd_pkg::CW-1:0]                        sx, sy, sz;
  logic [msd_pkg::LANES-1:0]                     out_flag;
  logic [msd_pkg::LANES-1:0][msd_pkg::CW-1:0]    exc;
  logic [msd_pkg::CW-1:0]                        min01, min23, min_all;
  logic [msd_pkg::SAT_W-1:0]                     min_ext;
  logic                                          valid_d;
  msd_pkg::msd_word_t                            word_d;
  logic                                          valid_q;
  msd_pkg::msd_word_t                            word_q;

  // Sign-extend the inputs and form the four coordinates.
  always_comb begin
    sx = {{EXT{px_i[msd_pkg::IN_W-1]}}, px_i};
    sy = {{EXT{py_i[msd_pkg::IN_W-1]}}, py_i};
    sz = {{EXT{pz_i[msd_pkg::IN_W-1]}}, pz_i};
    c_d[0] = sx + msd_pkg::HALF_C;
    c_d[1] = sy + msd_pkg::HALF_C;
    c_d[2] = sz + msd_pkg::HALF_C;
    c_d[3] = msd_pkg::ONE_C + sx - sy - sz;
  end

  // First stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  // Out-of-range excess per coordinate; lanes in range read as all ones.
  always_comb begin
    for (int i = 0; i < msd_pkg::LANES; i++) begin
      if (c_q[i][msd_pkg::CW-1]) begin
        out_flag[i] = 1'b1;
        exc[i]      = -c_q[i];
      end else if (c_q[i] > msd_pkg::ONE_C) begin
        out_flag[i] = 1'b1;
        exc[i]      = c_q[i] - msd_pkg::ONE_C;
      end else begin
        out_flag[i] = 1'b0;
        exc[i]      = '1;
      end
    end
    min01   = (exc[1] < exc[0]) ? exc[1] : exc[0];
    min23   = (exc[3] < exc[2]) ? exc[3] : exc[2];
    min_all = (min23 < min01) ? min23 : min01;
    min_ext = msd_pkg::SAT_W'(min_all);
  end

  // Build the word for the first cell.
  always_comb begin
    valid_d         = valid_a_q;
    word_d.resolved = |out_flag;
    word_d.hole     = 1'b0;
    word_d.lvl      = msd_pkg::LVL_W'(1);
    if (!(|out_flag)) begin
      word_d.val = '0;
    end else if (min_ext > msd_pkg::DIST_MAX_C) begin
      word_d.val = msd_pkg::DIST_W'(msd_pkg::DIST_MAX_C);
    end else begin
      word_d.val = msd_pkg::DIST_W'(min_ext);
    end
    for (int i = 0; i < msd_pkg::LANES; i++) begin
      word_d.t[i] = c_q[i][msd_pkg::TW-1:0];
    end
  end

  // Second stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// File: hdl/msd_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Slice distance level cell
// One ternary level: multiplies each coordinate fraction by three modulo
// three, tests for the hole and resolves the word when two or more lanes hit.
// ----------------------------------------------------------------------------
module msd_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  msd_pkg::msd_word_t word_i,
  output logic               valid_o,
  output msd_pkg::msd_word_t word_o
);

  localparam int unsigned F = msd_pkg::FRAC_BITS;

  logic [msd_pkg::LANES-1:0][msd_pkg::UW-1:0]   u;
  logic [msd_pkg::LANES-1:0][msd_pkg::UW-1:0]   u_mod;
  logic [msd_pkg::LANES-1:0][msd_pkg::TW-1:0]   t_next;
  logic [msd_pkg::LANES-1:0][F-1:0]             r;
  logic [msd_pkg::LANES-1:0][F:0]               comp;
  logic [msd_pkg::LANES-1:0]                    hole;
  logic [msd_pkg::LANES-1:0][msd_pkg::DMW-1:0]  dist_l;
  logic [msd_pkg::DMW-1:0]                      min01, min23, dmin;
  logic [2:0]                                   hole_cnt;
  msd_pkg::msd_word_t                           word_d;
  logic                                         valid_q;
  msd_pkg::msd_word_t                           word_q;

  // Per lane: t = 3t mod 3, digit, remainder and distance to the hole edge.
  always_comb begin
    for (int i = 0; i < msd_pkg::LANES; i++) begin
      u[i] = (msd_pkg::UW'(word_i.t[i]) << 1) + msd_pkg::UW'(word_i.t[i]);
      if (u[i] >= msd_pkg::SIX_U) begin
        u_mod[i] = u[i] - msd_pkg::SIX_U;
      end else if (u[i] >= msd_pkg::THREE_U) begin
        u_mod[i] = u[i] - msd_pkg::THREE_U;
      end else begin
        u_mod[i] = u[i];
      end
      t_next[i] = u_mod[i][msd_pkg::TW-1:0];
      r[i]      = t_next[i][F-1:0];
      hole[i]   = (t_next[i][msd_pkg::TW-1:F] == 2'd1) && (r[i] != '0);
      comp[i]   = msd_pkg::ONE_R - {1'b0, r[i]};
      if (!hole[i]) begin
        dist_l[i] = '1;
      end else if (comp[i] < {1'b0, r[i]}) begin
        dist_l[i] = comp[i][F-1:0];
      end else begin
        dist_l[i] = r[i];
      end
    end
    min01    = (dist_l[1] < dist_l[0]) ? dist_l[1] : dist_l[0];
    min23    = (dist_l[3] < dist_l[2]) ? dist_l[3] : dist_l[2];
    dmin     = (min23 < min01) ? min23 : min01;
    hole_cnt = 3'(hole[0]) + 3'(hole[1]) + 3'(hole[2]) + 3'(hole[3]);
  end

  // Resolved words pass unchanged; open words resolve on a hole hit or advance one level.
  always_comb begin
    word_d = word_i;
    if (!word_i.resolved) begin
      word_d.t = t_next;
      if (hole_cnt >= 3'd2) begin
        word_d.resolved = 1'b1;
        word_d.hole     = 1'b1;
        word_d.val      = msd_pkg::DIST_W'(dmin);
      end else begin
        word_d.lvl = word_i.lvl + msd_pkg::LVL_W'(1);
      end
    end
  end

  // Cell register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

  // A resolved word keeps its level; a hole hit always carries a nonzero distance.
  `MSD_ASSERT_IMPL(a_cell_hold, clk_i, rst_ni, valid_i && word_i.resolved, ##1 (word_q.resolved && word_q.lvl == $past(word_i.lvl)), "resolved word changed its level in a cell")
  `MSD_ASSERT(a_cell_hole_nz, clk_i, rst_ni, (valid_q && word_q.hole) |-> (word_q.val != '0), "hole hit with zero distance")

endmodule

// File: hdl/msd_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slice distance output stage
// Scales a hole distance by 3^-level with a reciprocal multiply and shift,
// then registers the result word and its strobe.
// ----------------------------------------------------------------------------
module msd_tail (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  msd_pkg::msd_word_t          word_i,
  output logic                        done_o,
  output logic [msd_pkg::DIST_W-1:0]  distance_o,
  output logic                        inside_res_o
);

  logic                               valid_m_q;
  logic                               resolved_q, hole_q;
  logic [msd_pkg::LVL_W-1:0]          lvl_q;
  logic [msd_pkg::DIST_W-1:0]         val_q;
  logic [msd_pkg::PROD_W-1:0]         prod_d, prod_q;
  logic [msd_pkg::PROD_W-1:0]         shifted;
  logic [msd_pkg::DMW-1:0]            quo;
  logic [msd_pkg::DIST_W-1:0]         dist_d, dist_q;
  logic                               inside_d, inside_q;
  logic                               done_q;

  // Reciprocal multiply for the level the word stopped at.
  assign prod_d = msd_pkg::PROD_W'(word_i.val[msd_pkg::DMW-1:0])
                * msd_pkg::PROD_W'(msd_pkg::MAG_TBL[word_i.lvl]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
    end else begin
      valid_m_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    resolved_q <= word_i.resolved;
    hole_q     <= word_i.hole;
    lvl_q      <= word_i.lvl;
    val_q      <= word_i.val;
    prod_q     <= prod_d;
  end

  // Shift out the quotient and select the final distance.
  always_comb begin
    shifted  = prod_q >> msd_pkg::SHIFT_TBL[lvl_q];
    quo      = shifted[msd_pkg::DMW-1:0];
    inside_d = !resolved_q;
    if (!resolved_q) begin
      dist_d = '0;
    end else if (hole_q) begin
      dist_d = (quo == '0) ? msd_pkg::DIST_W'(1) : msd_pkg::DIST_W'(quo);
    end else begin
      dist_d = val_q;
    end
  end

  // Output register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q   <= dist_d;
    inside_q <= inside_d;
  end

  assign done_o       = done_q;
  assign distance_o   = dist_q;
  assign inside_res_o = inside_q;

endmodule
